>>> hw/rtl/scf_pkg.sv
// Shared constants, types and codes of the sliding correlation filter.
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

    // Sizes of the filter.
    localparam int TAPS           = 16;
    localparam int SAMPLE_BITS    = 16;
    localparam int RESULT_BITS    = 36;
    localparam int PROD_BITS      = 2 * SAMPLE_BITS;
    localparam int COEF_IDX_BITS  = 4;
    localparam int MASK_LEN_BITS  = 5;
    localparam int MASK_LEN_RESET = 16;
    localparam int LEN_BITS       = $clog2(TAPS + 1);
    localparam int TAP_IDX_BITS   = (TAPS > 1) ? $clog2(TAPS) : 1;

    // Item mode codes.
    localparam logic MODE_COEF   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [RESULT_BITS-1:0] acc_t;
    typedef logic [COEF_IDX_BITS-1:0]      coef_idx_t;
    typedef logic [MASK_LEN_BITS-1:0]      mask_len_t;
    typedef logic [LEN_BITS-1:0]           len_t;
    typedef logic [TAP_IDX_BITS-1:0]       tap_idx_t;

    // Moves shared by every cell of the chain.
    typedef struct packed {
        logic shift_sample;
        logic rotate_coef;
        logic shift_acoef;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/scf_cell.sv
// One cell of the correlation chain: a sample tap, a coefficient, a product and a partial sum.
`timescale 1ns / 1ps
`default_nettype none

module scf_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scf_pkg::cell_ctl_t ctl,
    input  wire logic              coef_wr,
    input  wire logic              acoef_wr,
    input  wire logic              in_window,
    input  wire scf_pkg::sample_t  wr_data,
    input  wire scf_pkg::sample_t  sample_in,
    input  wire scf_pkg::sample_t  coef_in,
    input  wire scf_pkg::sample_t  acoef_in,
    input  wire logic              tok_in,
    input  wire scf_pkg::acc_t     psum_in,
    output scf_pkg::sample_t       sample_out,
    output scf_pkg::sample_t       coef_out,
    output scf_pkg::sample_t       acoef_out,
    output logic                   tok_out,
    output scf_pkg::acc_t          psum_out
);

    scf_pkg::sample_t sample_reg, sample_next;
    scf_pkg::sample_t coef_reg, coef_next;
    scf_pkg::sample_t acoef_reg, acoef_next;
    scf_pkg::prod_t   prod_reg, prod_next;
    scf_pkg::acc_t    psum_reg, psum_next;
    logic             tok_reg;

    // The sample tap moves one place down the line on every pushed sample.
    assign sample_next = ctl.shift_sample ? sample_in : sample_reg;

    // Coefficient in natural order: written by index, rotated around the ring on a realign.
    always_comb
    begin
        coef_next = coef_reg;
        if (coef_wr)
        begin
            coef_next = wr_data;
        end
        else if (ctl.rotate_coef)
        begin
            coef_next = coef_in;
        end
    end

    // Coefficient aligned to this tap for the current mask length.
    always_comb
    begin
        acoef_next = acoef_reg;
        if (acoef_wr)
        begin
            acoef_next = wr_data;
        end
        else if (ctl.shift_acoef)
        begin
            acoef_next = acoef_in;
        end
    end

    // Product of the tap with its aligned coefficient, zero outside the window.
    always_comb
    begin
        prod_next = '0;
        if (in_window)
        begin
            prod_next = scf_pkg::prod_t'(sample_reg) * scf_pkg::prod_t'(acoef_reg);
        end
    end

    // The partial sum picks up this cell's product as the token passes.
    assign psum_next = tok_in ? (psum_in + scf_pkg::acc_t'(prod_reg)) : psum_reg;

    // State with a defined reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            coef_reg   <= '0;
            acoef_reg  <= '0;
            tok_reg    <= 1'b0;
        end
        else
        begin
            sample_reg <= sample_next;
            coef_reg   <= coef_next;
            acoef_reg  <= acoef_next;
            tok_reg    <= tok_in;
        end
    end

    // Arithmetic registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        psum_reg <= psum_next;
    end

    assign sample_out = sample_reg;
    assign coef_out   = coef_reg;
    assign acoef_out  = acoef_reg;
    assign tok_out    = tok_reg;
    assign psum_out   = psum_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sliding_correlation_filter.sv
// Top level of the sliding correlation filter: cell chain, sequencer and result register.
//
//   channel  direction  handshake                 word
//   item     in         item_valid / item_stall   mode, coef_index, value, first
//   result   out        res_valid / res_stall     result
//   config   in         cfg_valid / cfg_ready     mask_length
//
// Coefficient writes and samples that complete no window are taken back to back.
// A sample that completes a window holds items off through the prime, launch, run and drain
// steps, while the sum token ripples through the chain of TAPS cells, one cell a cycle.
// A mask_length write realigns the coefficients in a sweep around the ring; items wait meanwhile,
// and a pending config word holds items off so that it is taken first.
// Reset clears samples, coefficients and fill count, and sets mask_length to 16.
`timescale 1ns / 1ps
`default_nettype none

module sliding_correlation_filter (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic                mode,
    input  wire scf_pkg::coef_idx_t  coef_index,
    input  wire scf_pkg::sample_t    value,
    input  wire logic                first,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output scf_pkg::acc_t            result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire scf_pkg::mask_len_t  mask_length
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_LAUNCH,
        ST_RUN,
        ST_DRAIN,
        ST_SWEEP
    } state_t;

    state_t              state_reg, state_next;
    scf_pkg::mask_len_t  mask_len_reg, mask_len_next;
    scf_pkg::len_t       fill_reg, fill_next;
    scf_pkg::tap_idx_t   sweep_reg, sweep_next;
    logic                res_valid_reg, res_valid_next;
    scf_pkg::acc_t       result_reg, result_next;

    scf_pkg::len_t       len_act;
    scf_pkg::len_t       a_idx;
    logic                item_accept;
    logic                coef_acc;
    logic                samp_acc;
    logic                has_result;
    logic                res_free;
    logic                idx_in_len;
    scf_pkg::cell_ctl_t  ctl;
    logic [scf_pkg::TAPS-1:0] coef_wr;
    logic [scf_pkg::TAPS-1:0] acoef_wr;
    logic [scf_pkg::TAPS-1:0] in_window;

    scf_pkg::sample_t    sample_w [scf_pkg::TAPS];
    scf_pkg::sample_t    coef_w   [scf_pkg::TAPS];
    scf_pkg::sample_t    acoef_w  [scf_pkg::TAPS];
    logic                tok_w    [scf_pkg::TAPS];
    scf_pkg::acc_t       psum_w   [scf_pkg::TAPS];

    // Handshakes. A pending config word is taken before any item.
    assign item_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign coef_acc    = item_accept && (mode == scf_pkg::MODE_COEF);
    assign samp_acc    = item_accept && (mode == scf_pkg::MODE_SAMPLE);
    assign res_free    = !res_valid_reg || !res_stall;

    // Mask length in use: zero counts as one, anything above TAPS as TAPS.
    always_comb
    begin
        if (mask_len_reg == '0)
        begin
            len_act = scf_pkg::len_t'(1);
        end
        else if (32'(mask_len_reg) > scf_pkg::TAPS)
        begin
            len_act = scf_pkg::len_t'(scf_pkg::TAPS);
        end
        else
        begin
            len_act = scf_pkg::len_t'(mask_len_reg);
        end
    end

    // Fill count of the current signal, saturating at TAPS.
    always_comb
    begin
        fill_next = fill_reg;
        if (samp_acc)
        begin
            if (first)
            begin
                fill_next = scf_pkg::len_t'(1);
            end
            else if (fill_reg < scf_pkg::len_t'(scf_pkg::TAPS))
            begin
                fill_next = fill_reg + scf_pkg::len_t'(1);
            end
        end
    end

    assign has_result = (fill_next >= len_act);

    // Coefficient j multiplies the tap that is len_act-1-j samples old (the mask length in use).
    assign idx_in_len = (32'(coef_index) < 32'(len_act));
    assign a_idx      = len_act - scf_pkg::len_t'(1) - scf_pkg::len_t'(coef_index);

    // Per-cell write strobes and window flags.
    always_comb
    begin
        for (int k = 0; k < scf_pkg::TAPS; k++)
        begin
            coef_wr[k]   = coef_acc && (32'(coef_index) == k);
            acoef_wr[k]  = coef_acc && idx_in_len && (32'(a_idx) == k);
            in_window[k] = (k < 32'(len_act));
        end
    end

    // Chain moves: push on a sample, rotate and realign during a sweep.
    always_comb
    begin
        ctl.shift_sample = samp_acc;
        ctl.rotate_coef  = (state_reg == ST_SWEEP);
        ctl.shift_acoef  = (state_reg == ST_SWEEP) && (32'(sweep_reg) < 32'(len_act));
    end

    // The row of cells.
    for (genvar k = 0; k < scf_pkg::TAPS; k++)
    begin : g_cell
        scf_pkg::sample_t s_in;
        scf_pkg::sample_t a_in;
        logic             t_in;
        scf_pkg::acc_t    p_in;

        if (k == 0)
        begin : g_head
            assign s_in = value;
            assign a_in = coef_w[0];
            assign t_in = (state_reg == ST_LAUNCH);
            assign p_in = '0;
        end
        else
        begin : g_body
            assign s_in = sample_w[k-1];
            assign a_in = acoef_w[k-1];
            assign t_in = tok_w[k-1];
            assign p_in = psum_w[k-1];
        end

        scf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .coef_wr    (coef_wr[k]),
            .acoef_wr   (acoef_wr[k]),
            .in_window  (in_window[k]),
            .wr_data    (value),
            .sample_in  (s_in),
            .coef_in    (coef_w[(k + 1) % scf_pkg::TAPS]),
            .acoef_in   (a_in),
            .tok_in     (t_in),
            .psum_in    (p_in),
            .sample_out (sample_w[k]),
            .coef_out   (coef_w[k]),
            .acoef_out  (acoef_w[k]),
            .tok_out    (tok_w[k]),
            .psum_out   (psum_w[k])
        );
    end

    // Sequencer and result register.
    always_comb
    begin
        state_next     = state_reg;
        mask_len_next  = mask_len_reg;
        sweep_next     = sweep_reg;
        res_valid_next = res_valid_reg;
        result_next    = result_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    mask_len_next = mask_length;
                    sweep_next    = '0;
                    state_next    = ST_SWEEP;
                end
                else if (samp_acc && has_result)
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (tok_w[scf_pkg::TAPS-1])
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (res_free)
                begin
                    result_next    = psum_w[scf_pkg::TAPS-1];
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (32'(sweep_reg) == scf_pkg::TAPS - 1)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + scf_pkg::tap_idx_t'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_len_reg  <= scf_pkg::mask_len_t'(scf_pkg::MASK_LEN_RESET);
            fill_reg      <= '0;
            sweep_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mask_len_reg  <= mask_len_next;
            fill_reg      <= fill_next;
            sweep_reg     <= sweep_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign res_valid = res_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/scf_check.sv
// Port-level checks of the sliding correlation filter and their binding.
`timescale 1ns / 1ps
`default_nettype none

module scf_check (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire logic               mode,
    input wire scf_pkg::coef_idx_t coef_index,
    input wire scf_pkg::sample_t   value,
    input wire logic               first,
    input wire logic               res_valid,
    input wire logic               res_stall,
    input wire scf_pkg::acc_t      result,
    input wire logic               cfg_valid,
    input wire logic               cfg_ready,
    input wire scf_pkg::mask_len_t mask_length
);

    // A stalled result word holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(result))
        else $error("stalled result word changed");

    // Items are held off whenever the block is busy with other work.
    a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_ready |-> item_stall)
        else $error("items open while the block is busy");

    // A mask length write starts a realign that holds off items and config.
    a_cfg_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> item_stall && !cfg_ready)
        else $error("no realign after mask length write");

    // A coefficient word never yields a result.
    a_coef_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (mode == scf_pkg::MODE_COEF) && !res_valid
        |=> !res_valid)
        else $error("result after coefficient word");

    // A new result only comes out of the drain step, with items held off.
    a_res_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(item_stall))
        else $error("result appeared while items were open");

endmodule

bind sliding_correlation_filter scf_check u_scf_check (.*);

`default_nettype wire

>>> tb/sliding_correlation_filter_tb.sv
// Self-checking testbench for the sliding correlation filter: directed and random words.
`timescale 1ns / 1ps

module sliding_correlation_filter_tb;

    // Waiting time after the last expected sum before the mask length may change.
    localparam int SETTLE_CYCLES = scf_pkg::TAPS + 24;
    localparam int SEGMENTS      = 17;
    localparam int SEGMENT_WORDS = 100;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic               mode;
    scf_pkg::coef_idx_t coef_index;
    scf_pkg::sample_t   value;
    logic               first;
    logic               res_valid;
    logic               res_stall = 1'b0;
    scf_pkg::acc_t      result;
    logic               cfg_valid;
    logic               cfg_ready;
    scf_pkg::mask_len_t mask_length;

    // Idle percentages of the sender and of the receiver.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int words_sent = 0;

    // Software copy of the filter state.
    scf_pkg::sample_t   mdl_coef [scf_pkg::TAPS];
    scf_pkg::sample_t   mdl_line [scf_pkg::TAPS];
    int                 mdl_fill;
    scf_pkg::mask_len_t mdl_mask;

    // Correlation sums still owed by the block, oldest first.
    scf_pkg::acc_t sums_due [$];

    sliding_correlation_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .mode        (mode),
        .coef_index  (coef_index),
        .value       (value),
        .first       (first),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .mask_length (mask_length)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Clamp the programmed mask length to the usable range.
    function automatic int window_span(input scf_pkg::mask_len_t len);
        if (len == 0)
            return 1;
        if (len > scf_pkg::TAPS)
            return scf_pkg::TAPS;
        return int'(len);
    endfunction

    // Sample values that favor both ends of the range.
    function automatic scf_pkg::sample_t pick_value();
        case ($urandom_range(0, 7))
            0: return scf_pkg::sample_t'(16'sh8000);
            1: return scf_pkg::sample_t'(16'sh7FFF);
            2: return scf_pkg::sample_t'(16'sh0000);
            default: return scf_pkg::sample_t'($urandom);
        endcase
    endfunction

    // Apply one accepted word to the software copy and queue the sum it produces.
    task automatic track_word(input logic m, input scf_pkg::coef_idx_t idx,
                              input scf_pkg::sample_t v, input logic f);
        int     span;
        longint acc;
        begin
            if (m == scf_pkg::MODE_COEF)
            begin
                mdl_coef[idx] = v;
            end
            else
            begin
                for (int k = scf_pkg::TAPS - 1; k > 0; k--)
                    mdl_line[k] = mdl_line[k - 1];
                mdl_line[0] = v;
                if (f)
                    mdl_fill = 1;
                else if (mdl_fill < scf_pkg::TAPS)
                    mdl_fill++;
                span = window_span(mdl_mask);
                if (mdl_fill >= span)
                begin
                    acc = 0;
                    for (int j = 0; j < span; j++)
                        acc += longint'(mdl_line[span - 1 - j]) * longint'(mdl_coef[j]);
                    sums_due.push_back(scf_pkg::acc_t'(acc));
                end
            end
        end
    endtask

    // Send one word; called and returning at a falling edge.
    task automatic send_word(input logic m, input scf_pkg::coef_idx_t idx,
                             input scf_pkg::sample_t v, input logic f);
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                item_valid = 1'b0;
                value = pick_value();
                @(negedge clk);
            end
            item_valid = 1'b1;
            mode = m;
            coef_index = idx;
            value = v;
            first = f;
            @(posedge clk);
            while (item_stall)
                @(posedge clk);
            track_word(m, idx, v, f);
            words_sent++;
            @(negedge clk);
        end
    endtask

    // Wait until every owed sum has come out and the chain has gone quiet.
    task automatic drain();
        begin
            item_valid = 1'b0;
            while (sums_due.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // Write the mask length register while the block is idle.
    task automatic write_mask_length(input scf_pkg::mask_len_t len);
        begin
            drain();
            cfg_valid = 1'b1;
            mask_length = len;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            mdl_mask = len;
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    // Full-scale coefficients and samples, including the largest positive sum.
    task automatic test_extreme_products();
        begin
            write_mask_length(5'd2);
            send_word(scf_pkg::MODE_COEF, 4'd0, scf_pkg::sample_t'(16'sh8000), 1'b0);
            send_word(scf_pkg::MODE_COEF, 4'd1, scf_pkg::sample_t'(16'sh8000), 1'b1);
            send_word(scf_pkg::MODE_COEF, 4'd15, scf_pkg::sample_t'(16'sh7FFF), 1'b0);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(16'sh8000), 1'b1);
            send_word(scf_pkg::MODE_SAMPLE, 4'd15, scf_pkg::sample_t'(16'sh8000), 1'b0);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(16'sh7FFF), 1'b0);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(16'sh7FFF), 1'b0);
            // A coefficient changed mid-signal applies to the next sample.
            send_word(scf_pkg::MODE_COEF, 4'd1, scf_pkg::sample_t'(16'sh7FFF), 1'b0);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(16'sh8000), 1'b0);
        end
    endtask

    // A zero mask length acts as one, an oversized one as the full tap count.
    task automatic test_mask_bounds();
        begin
            write_mask_length(5'd0);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(16'sd12345), 1'b1);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(-16'sd1), 1'b0);
            write_mask_length(5'd31);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(16'sd100), 1'b0);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(-16'sd100), 1'b0);
        end
    endtask

    // The first flag restarts the fill count without clearing older samples.
    task automatic test_first_restart();
        begin
            write_mask_length(5'd3);
            send_word(scf_pkg::MODE_COEF, 4'd2, scf_pkg::sample_t'(16'sd7), 1'b1);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(16'sd3), 1'b1);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(-16'sd5), 1'b0);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(16'sd11), 1'b0);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(16'sd2), 1'b1);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(16'sh7FFF), 1'b0);
            send_word(scf_pkg::MODE_SAMPLE, 4'd0, scf_pkg::sample_t'(16'sh8000), 1'b0);
        end
    endtask

    // One stretch of random traffic: mostly whole signals, some noise.
    task automatic run_segment(input int count);
        int stop_at;
        int span;
        int sig_len;
        begin
            stop_at = words_sent + count;
            span = window_span(mdl_mask);
            while (words_sent < stop_at)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    // Load part or all of the active mask, then one signal.
                    for (int j = 0; j < span; j++)
                        if ($urandom_range(0, 2) != 0)
                            send_word(scf_pkg::MODE_COEF, scf_pkg::coef_idx_t'(j),
                                      pick_value(), 1'($urandom));
                    sig_len = span + $urandom_range(0, 20);
                    for (int s = 0; s < sig_len; s++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_word(scf_pkg::MODE_COEF,
                                      scf_pkg::coef_idx_t'($urandom_range(0, span - 1)),
                                      pick_value(), 1'($urandom));
                        send_word(scf_pkg::MODE_SAMPLE, scf_pkg::coef_idx_t'($urandom),
                                  pick_value(), s == 0);
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 8))
                        send_word(1'($urandom), scf_pkg::coef_idx_t'($urandom),
                                  pick_value(), $urandom_range(0, 3) == 0);
                end
            end
        end
    endtask

    // Random segments across many mask lengths and three idling patterns.
    task automatic test_random_traffic();
        scf_pkg::mask_len_t lengths [8];
        begin
            lengths = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd15};
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                if (seg < SEGMENTS / 3)
                begin
                    send_idle_pct = 25;
                    recv_stall_pct = 72;
                end
                else if (seg < 2 * SEGMENTS / 3)
                begin
                    send_idle_pct = 72;
                    recv_stall_pct = 25;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                if (seg < 8)
                    write_mask_length(lengths[seg]);
                else
                    write_mask_length(scf_pkg::mask_len_t'($urandom_range(0, 31)));
                run_segment(SEGMENT_WORDS);
            end
        end
    endtask

    // Receiver stall, changed at the falling edge.
    always @(negedge clk)
    begin
        res_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Compare each accepted result word with the oldest owed sum.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (sums_due.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %0d",
                         $time, result);
                mismatches++;
            end
            else if (result !== sums_due[0])
            begin
                $display("%0t: result mismatch, expected %0d, actual %0d",
                         $time, sums_due[0], result);
                mismatches++;
                void'(sums_due.pop_front());
            end
            else
            begin
                void'(sums_due.pop_front());
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        mode = scf_pkg::MODE_COEF;
        coef_index = '0;
        value = '0;
        first = 1'b0;
        cfg_valid = 1'b0;
        mask_length = scf_pkg::mask_len_t'(scf_pkg::MASK_LEN_RESET);
        for (int k = 0; k < scf_pkg::TAPS; k++)
        begin
            mdl_coef[k] = '0;
            mdl_line[k] = '0;
        end
        mdl_fill = 0;
        mdl_mask = scf_pkg::mask_len_t'(scf_pkg::MASK_LEN_RESET);
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 25;
        recv_stall_pct = 72;
        test_extreme_products();
        test_mask_bounds();
        test_first_restart();
        test_random_traffic();

        drain();
        if (mismatches == 0)
            $display("sliding_correlation_filter_tb OK");
        else
            $display("sliding_correlation_filter_tb NOT OK");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #4000000;
        $display("sliding_correlation_filter_tb NOT OK");
        $finish;
    end

endmodule
